FILE: design/fifo_queue_keyed_removal_assert.svh
// ----------------------------------------------------------------------------
// assertion macros for the keyed-removal request queue
// ----------------------------------------------------------------------------
`ifndef FIFO_QUEUE_KEYED_REMOVAL_ASSERT_SVH
`define FIFO_QUEUE_KEYED_REMOVAL_ASSERT_SVH

// same-cycle implication
`define FQKR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication failed");

// next-cycle implication
`define FQKR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle implication failed");

`endif

FILE: design/fqkr_pkg.sv
// ----------------------------------------------------------------------------
// fqkr_pkg
// operation, status, state and cell command codes for the request queue
// ----------------------------------------------------------------------------
`default_nettype none

package fqkr_pkg;

   // operation selected by one request beat
   typedef enum logic [1:0] {
      FUNC_ENQUEUE      = 2'd0,
      FUNC_DEQUEUE      = 2'd1,
      FUNC_REMOVE_MATCH = 2'd2,
      FUNC_REMOVE_POS   = 2'd3
   } func_type;

   // result status
   typedef enum logic [2:0] {
      STATUS_OK       = 3'd0,
      STATUS_EMPTY    = 3'd1,
      STATUS_RANGE    = 3'd2,
      STATUS_NO_MATCH = 3'd3,
      STATUS_FULL     = 3'd4
   } status_type;

   // controller sequencing
   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_START = 2'd1,
      ST_SCAN  = 2'd2,
      ST_DONE  = 2'd3
   } state_type;

   // command broadcast to every cell of the chain
   typedef enum logic [1:0] {
      CMD_HOLD   = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_DROP   = 2'd2,
      CMD_ROTATE = 2'd3
   } cell_cmd_type;

endpackage

`default_nettype wire

FILE: design/fifo_queue_keyed_removal.sv
// ----------------------------------------------------------------------------
// fifo_queue_keyed_removal
// ordered request queue held in a chain of cells, with enqueue, dequeue,
// removal of the first matching word and removal by position
//
//   channel   beat moves                          flow control
//   req_      func, entry_value, position         req_valid / req_stall
//   rsp_      status, removed_value, count        rsp_valid / rsp_stall
//
// enqueue, dequeue and removals refused at decode raise rsp_valid once the
// controller has passed its start and done states; the next request is then
// taken on the return to idle. removal by match or position adds a scan state
// between the two, in which the chain rotates once past the head cell.
// one request is in flight at a time; the next is taken while a result waits.
// reset clears the sequencer, the fill level and the response valid only.
// a stalled response holds the controller in its final state.
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_queue_keyed_removal #(
   parameter int DEPTH       = 64,
   parameter int ENTRY_WIDTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_func,
   input  wire logic [31:0] req_entry_value,
   input  wire logic [6:0]  req_position,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic      [2:0]  rsp_status,
   output logic      [31:0] rsp_removed_value,
   output logic      [6:0]  rsp_count
);

   localparam int CW = $clog2(DEPTH + 1);

   fqkr_pkg::cell_cmd_type  cell_cmd;
   logic [CW-1:0]           cell_count;
   logic [ENTRY_WIDTH-1:0]  cell_word;
   logic [ENTRY_WIDTH-1:0]  cell_value [DEPTH];

   // sequencer
   fqkr_ctrl #(
      .DEPTH       (DEPTH),
      .ENTRY_WIDTH (ENTRY_WIDTH),
      .CW          (CW)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_entry_value   (req_entry_value),
      .req_position      (req_position),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_removed_value (rsp_removed_value),
      .rsp_count         (rsp_count),
      .head_value        (cell_value[0]),
      .cell_cmd          (cell_cmd),
      .cell_count        (cell_count),
      .cell_word         (cell_word)
   );

   // chain of slots, head at index zero
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [ENTRY_WIDTH-1:0] next_value;

      if (i == DEPTH - 1) begin : g_last
         assign next_value = cell_value[i];
      end else begin : g_mid
         assign next_value = cell_value[i+1];
      end

      fqkr_cell #(
         .INDEX       (i),
         .ENTRY_WIDTH (ENTRY_WIDTH),
         .CW          (CW)
      ) u_cell (
         .clock      (clock),
         .cmd        (cell_cmd),
         .count      (cell_count),
         .word       (cell_word),
         .head_value (cell_value[0]),
         .next_value (next_value),
         .value      (cell_value[i])
      );
   end

endmodule

`default_nettype wire

FILE: design/fqkr_cell.sv
// ----------------------------------------------------------------------------
// fqkr_cell
// one queue slot; loads the appended word, takes its right neighbour on a
// shift, or takes the head word when it is the tail slot of a rotation
// ----------------------------------------------------------------------------
`default_nettype none

module fqkr_cell #(
   parameter int INDEX       = 0,
   parameter int ENTRY_WIDTH = 32,
   parameter int CW          = 7
) (
   input  wire logic                     clock,
   input  wire fqkr_pkg::cell_cmd_type   cmd,
   input  wire logic [CW-1:0]            count,
   input  wire logic [ENTRY_WIDTH-1:0]   word,
   input  wire logic [ENTRY_WIDTH-1:0]   head_value,
   input  wire logic [ENTRY_WIDTH-1:0]   next_value,
   output logic      [ENTRY_WIDTH-1:0]   value
);

   logic [ENTRY_WIDTH-1:0] value_ff;
   logic [ENTRY_WIDTH-1:0] value_in;

   // slot update from the broadcast command
   always_comb begin
      case (cmd)
         fqkr_pkg::CMD_HOLD: begin
            value_in = value_ff;
         end
         fqkr_pkg::CMD_APPEND: begin
            value_in = (count == CW'(INDEX)) ? word : value_ff;
         end
         fqkr_pkg::CMD_DROP: begin
            value_in = next_value;
         end
         fqkr_pkg::CMD_ROTATE: begin
            // tail slot of the occupied part receives the old head
            value_in = (count == CW'(INDEX + 1)) ? head_value : next_value;
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

`default_nettype wire

FILE: design/fqkr_ctrl.sv
// ----------------------------------------------------------------------------
// fqkr_ctrl
// sequencer for the cell chain: decodes a request, drives the cell command,
// inspects the head cell during a scan and holds the response register
// ----------------------------------------------------------------------------
`default_nettype none

module fqkr_ctrl #(
   parameter int DEPTH       = 64,
   parameter int ENTRY_WIDTH = 32,
   parameter int CW          = 7
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [1:0]               req_func,
   input  wire logic [31:0]              req_entry_value,
   input  wire logic [6:0]               req_position,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic      [2:0]               rsp_status,
   output logic      [31:0]              rsp_removed_value,
   output logic      [6:0]               rsp_count,
   input  wire logic [ENTRY_WIDTH-1:0]   head_value,
   output fqkr_pkg::cell_cmd_type        cell_cmd,
   output logic      [CW-1:0]            cell_count,
   output logic      [ENTRY_WIDTH-1:0]   cell_word
);

   localparam int PW = CW + 7;

   fqkr_pkg::state_type     state_ff, state_in;
   fqkr_pkg::func_type      func_ff, func_in;
   fqkr_pkg::status_type    status_ff, status_in;
   fqkr_pkg::status_type    rsp_status_ff;
   logic [ENTRY_WIDTH-1:0]  word_ff, word_in;
   logic [6:0]              pos_ff, pos_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [CW-1:0]           step_ff, step_in;
   logic [CW-1:0]           total_ff, total_in;
   logic [CW-1:0]           target_ff, target_in;
   logic                    found_ff, found_in;
   logic [ENTRY_WIDTH-1:0]  removed_ff, removed_in;
   logic                    rsp_valid_ff;
   logic [31:0]             rsp_removed_ff;
   logic [6:0]              rsp_count_ff;

   logic                    accept;
   logic                    rsp_load;
   logic                    out_free;
   logic                    full;
   logic                    empty;
   logic                    range_err;
   logic                    head_hit;
   logic                    drop_now;
   logic                    last_step;
   logic [ENTRY_WIDTH+31:0] word_wide;
   logic [ENTRY_WIDTH+31:0] removed_wide;
   logic [PW-1:0]           pos_ext;
   logic [PW-1:0]           pos_eff;
   logic [PW-1:0]           count_ext;
   logic [PW-1:0]           target_wide;

   // request word fitted to the entry width
   assign word_wide = {{ENTRY_WIDTH{1'b0}}, req_entry_value};

   // position checks, zero counts as the head
   assign pos_ext     = {{CW{1'b0}}, pos_ff};
   assign pos_eff     = (pos_ff == 7'd0) ? PW'(1) : pos_ext;
   assign count_ext   = {7'd0, count_ff};
   assign range_err   = pos_eff > count_ext;
   assign target_wide = pos_eff - PW'(1);

   // fill level flags
   assign full  = count_ff == CW'(DEPTH);
   assign empty = count_ff == '0;

   // head cell inspection during a scan
   assign head_hit  = (func_ff == fqkr_pkg::FUNC_REMOVE_MATCH) ? (head_value == word_ff)
                                                                : (step_ff == target_ff);
   assign drop_now  = !found_ff && head_hit;
   assign last_step = step_ff == (total_ff - CW'(1));

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign accept   = req_valid && !req_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fqkr_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = fqkr_pkg::ST_START;
            end
         end
         fqkr_pkg::ST_START: begin
            case (func_ff)
               fqkr_pkg::FUNC_ENQUEUE, fqkr_pkg::FUNC_DEQUEUE: begin
                  state_in = fqkr_pkg::ST_DONE;
               end
               fqkr_pkg::FUNC_REMOVE_MATCH: begin
                  state_in = empty ? fqkr_pkg::ST_DONE : fqkr_pkg::ST_SCAN;
               end
               fqkr_pkg::FUNC_REMOVE_POS: begin
                  state_in = (empty || range_err) ? fqkr_pkg::ST_DONE : fqkr_pkg::ST_SCAN;
               end
               default: begin
                  state_in = fqkr_pkg::ST_DONE;
               end
            endcase
         end
         fqkr_pkg::ST_SCAN: begin
            if (last_step) begin
               state_in = fqkr_pkg::ST_DONE;
            end
         end
         fqkr_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = fqkr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fqkr_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs and datapath updates
   always_comb begin
      req_stall  = state_ff != fqkr_pkg::ST_IDLE;
      cell_cmd   = fqkr_pkg::CMD_HOLD;
      rsp_load   = 1'b0;
      func_in    = func_ff;
      word_in    = word_ff;
      pos_in     = pos_ff;
      count_in   = count_ff;
      step_in    = step_ff;
      total_in   = total_ff;
      target_in  = target_ff;
      found_in   = found_ff;
      status_in  = status_ff;
      removed_in = removed_ff;
      case (state_ff)
         fqkr_pkg::ST_IDLE: begin
            if (accept) begin
               func_in = fqkr_pkg::func_type'(req_func);
               word_in = word_wide[ENTRY_WIDTH-1:0];
               pos_in  = req_position;
            end
         end
         fqkr_pkg::ST_START: begin
            status_in  = fqkr_pkg::STATUS_OK;
            removed_in = '0;
            step_in    = '0;
            found_in   = 1'b0;
            total_in   = count_ff;
            target_in  = target_wide[CW-1:0];
            case (func_ff)
               fqkr_pkg::FUNC_ENQUEUE: begin
                  if (full) begin
                     status_in = fqkr_pkg::STATUS_FULL;
                  end else begin
                     cell_cmd = fqkr_pkg::CMD_APPEND;
                     count_in = count_ff + CW'(1);
                  end
               end
               fqkr_pkg::FUNC_DEQUEUE: begin
                  if (empty) begin
                     status_in = fqkr_pkg::STATUS_EMPTY;
                  end else begin
                     cell_cmd   = fqkr_pkg::CMD_DROP;
                     removed_in = head_value;
                     count_in   = count_ff - CW'(1);
                  end
               end
               fqkr_pkg::FUNC_REMOVE_MATCH: begin
                  status_in = empty ? fqkr_pkg::STATUS_EMPTY : fqkr_pkg::STATUS_NO_MATCH;
               end
               fqkr_pkg::FUNC_REMOVE_POS: begin
                  if (empty) begin
                     status_in = fqkr_pkg::STATUS_EMPTY;
                  end else if (range_err) begin
                     status_in = fqkr_pkg::STATUS_RANGE;
                  end
               end
               default: begin
                  status_in = fqkr_pkg::STATUS_OK;
               end
            endcase
         end
         fqkr_pkg::ST_SCAN: begin
            // head either leaves the queue or goes round to the tail
            step_in = step_ff + CW'(1);
            if (drop_now) begin
               cell_cmd  = fqkr_pkg::CMD_DROP;
               count_in  = count_ff - CW'(1);
               found_in  = 1'b1;
               status_in = fqkr_pkg::STATUS_OK;
               if (func_ff == fqkr_pkg::FUNC_REMOVE_POS) begin
                  removed_in = head_value;
               end
            end else begin
               cell_cmd = fqkr_pkg::CMD_ROTATE;
            end
         end
         fqkr_pkg::ST_DONE: begin
            rsp_load = out_free;
         end
         default: begin
            cell_cmd = fqkr_pkg::CMD_HOLD;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fqkr_pkg::ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // operation registers
   always_ff @(posedge clock) begin
      func_ff    <= func_in;
      word_ff    <= word_in;
      pos_ff     <= pos_in;
      step_ff    <= step_in;
      total_ff   <= total_in;
      target_ff  <= target_in;
      found_ff   <= found_in;
      status_ff  <= status_in;
      removed_ff <= removed_in;
   end

   // response register
   assign removed_wide = {32'd0, removed_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff  <= status_ff;
         rsp_removed_ff <= removed_wide[31:0];
         rsp_count_ff   <= count_ext[6:0];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_count         = rsp_count_ff;
   assign cell_count        = count_ff;
   assign cell_word         = word_ff;

endmodule

`default_nettype wire

FILE: design/fqkr_checker.sv
// ----------------------------------------------------------------------------
// fqkr_checker
// port-level checks on the request queue, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "fifo_queue_keyed_removal_assert.svh"

module fqkr_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [2:0]  rsp_status,
   input wire logic [31:0] rsp_removed_value,
   input wire logic [6:0]  rsp_count
);

   // one request in flight: an accepted beat closes the request side
   `FQKR_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && !req_stall, req_stall)

   // a stalled response beat holds
   `FQKR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status) && $stable(rsp_removed_value) && $stable(rsp_count))

   // empty status only ever reports an empty queue with nothing removed
   `FQKR_ASSERT_IMPLY(a_empty_count, clock, reset, rsp_valid && (rsp_status == fqkr_pkg::STATUS_EMPTY), (rsp_count == 7'd0) && (rsp_removed_value == 32'd0))

   // no response straight after reset
   `FQKR_ASSERT_NEXT(a_reset_clear, clock, 1'b0, reset, !rsp_valid)

endmodule

bind fifo_queue_keyed_removal fqkr_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_status        (rsp_status),
   .rsp_removed_value (rsp_removed_value),
   .rsp_count         (rsp_count)
);

`default_nettype wire

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench for fifo_queue_keyed_removal
// drives enqueue, dequeue, match removal and positional removal beats and
// predicts every response from a queue-based shadow of the stored words;
// both channels idle and stall at random, with one long response hold-off
// and several pauses where the sender waits for every response to return
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUEUE_DEPTH = 64;

   // one request beat as the stimulus generator plans it
   typedef struct {
      fqkr_pkg::func_type   func;
      logic [31:0]          value;
      logic [6:0]           position;
      int unsigned          gap;
      bit                   drain_first;
   } queue_op_type;

   // one response beat as predicted
   typedef struct {
      fqkr_pkg::status_type status;
      logic [31:0]          removed;
      logic [6:0]           count;
   } queue_result_type;

   logic        clock;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_stall;
   logic [1:0]  req_func        = fqkr_pkg::FUNC_ENQUEUE;
   logic [31:0] req_entry_value = '0;
   logic [6:0]  req_position    = '0;
   logic        rsp_valid;
   logic        rsp_stall       = 1'b0;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_removed_value;
   logic [6:0]  rsp_count;

   queue_op_type     pending_ops[$];
   queue_result_type expected_results[$];
   logic [31:0]      held_words[$];
   logic [31:0]      word_pool[8];
   bit               burst_phase = 1'b0;
   logic             all_done    = 1'b1;
   logic             stim_done   = 1'b0;
   int unsigned      error_count = 0;
   int unsigned      requests_seen = 0;
   int unsigned      status_tally[5] = '{default: 0};
   int unsigned      peak_fill = 0;

   fifo_queue_keyed_removal i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_entry_value   (req_entry_value),
      .req_position      (req_position),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_removed_value (rsp_removed_value),
      .rsp_count         (rsp_count)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // idle cycles after a beat: mostly none or short, now and then long
   function automatic int unsigned idle_gap();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (burst_phase || pick < 55) return 0;
      if (pick < 88) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic void add_op(fqkr_pkg::func_type f, logic [31:0] v, logic [6:0] p,
                                  bit drain);
      queue_op_type op;
      op.func        = f;
      op.value       = v;
      op.position    = p;
      op.gap         = idle_gap();
      op.drain_first = drain;
      pending_ops.push_back(op);
   endfunction

   // random beat; words mostly from a small pool so matches and duplicates occur
   function automatic queue_op_type random_op(int unsigned enq_pct);
      queue_op_type op;
      op.func = fqkr_pkg::FUNC_ENQUEUE;
      if ($urandom_range(0, 99) >= enq_pct) begin
         case ($urandom_range(0, 2))
            0:       op.func = fqkr_pkg::FUNC_DEQUEUE;
            1:       op.func = fqkr_pkg::FUNC_REMOVE_MATCH;
            default: op.func = fqkr_pkg::FUNC_REMOVE_POS;
         endcase
      end
      op.value       = ($urandom_range(0, 99) < 70) ? word_pool[$urandom_range(0, 7)]
                                                    : $urandom();
      op.position    = ($urandom_range(0, 99) < 60) ? 7'($urandom_range(0, 8))
                                                    : 7'($urandom_range(0, 64));
      op.gap         = idle_gap();
      op.drain_first = 1'b0;
      return op;
   endfunction

   // empty the queue, fill it past the brim, then remove at the far end
   function automatic void add_fill_sequence();
      for (int i = 0; i < QUEUE_DEPTH; i++)
         add_op(fqkr_pkg::FUNC_DEQUEUE, $urandom(), 7'($urandom_range(0, 64)), i == 0);
      for (int i = 0; i < QUEUE_DEPTH + 2; i++)
         add_op(fqkr_pkg::FUNC_ENQUEUE,
                ($urandom_range(0, 1) != 0) ? word_pool[$urandom_range(0, 7)] : $urandom(),
                7'($urandom_range(0, 64)), 1'b0);
      add_op(fqkr_pkg::FUNC_REMOVE_POS, $urandom(), 7'd64, 1'b0);
      add_op(fqkr_pkg::FUNC_REMOVE_POS, $urandom(), 7'd64, 1'b0);
      add_op(fqkr_pkg::FUNC_REMOVE_POS, $urandom(), 7'd63, 1'b0);
   endfunction

   // shadow of the stored words: works out the response to one accepted beat
   function automatic queue_result_type apply_queue_op(queue_op_type op);
      queue_result_type res;
      int               hit;
      int               slot;
      res.status  = fqkr_pkg::STATUS_OK;
      res.removed = '0;
      if (op.func == fqkr_pkg::FUNC_ENQUEUE) begin
         if (held_words.size() >= QUEUE_DEPTH) res.status = fqkr_pkg::STATUS_FULL;
         else held_words.push_back(op.value);
      end else if (held_words.size() == 0) begin
         res.status = fqkr_pkg::STATUS_EMPTY;
      end else if (op.func == fqkr_pkg::FUNC_DEQUEUE) begin
         res.removed = held_words.pop_front();
      end else if (op.func == fqkr_pkg::FUNC_REMOVE_MATCH) begin
         // first equal word counted from the head
         hit = -1;
         foreach (held_words[i])
            if (hit < 0 && held_words[i] == op.value) hit = i;
         if (hit < 0) res.status = fqkr_pkg::STATUS_NO_MATCH;
         else held_words.delete(hit);
      end else begin
         // position zero acts as the head
         slot = (op.position == 0) ? 1 : int'(op.position);
         if (slot > held_words.size()) begin
            res.status = fqkr_pkg::STATUS_RANGE;
         end else begin
            res.removed = held_words[slot-1];
            held_words.delete(slot-1);
         end
      end
      res.count = 7'(held_words.size());
      return res;
   endfunction

   function automatic void report_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                  $realtime, field, want, got);
         error_count++;
      end
   endfunction

   // request driver
   always @(posedge clock) begin
      queue_op_type op;
      logic         fire;
      logic         next_valid;
      int unsigned  gap_left;
      if (reset) begin
         req_valid <= 1'b0;
         stim_done <= 1'b0;
         gap_left  = 0;
      end else begin
         fire       = req_valid && !req_stall;
         next_valid = req_valid && !fire;
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_ops.size() > 0 &&
                         !(pending_ops[0].drain_first && (fire || !all_done))) begin
               op = pending_ops.pop_front();
               req_func        <= op.func;
               req_entry_value <= op.value;
               req_position    <= op.position;
               gap_left        = op.gap;
               next_valid      = 1'b1;
            end
            req_valid <= next_valid;
         end
         stim_done <= (pending_ops.size() == 0) && !next_valid;
      end
   end

   // response stall: random runs, plus one long hold-off
   always @(posedge clock) begin
      int unsigned rsp_taken;
      int unsigned run_left;
      int unsigned hold_left;
      int unsigned pick;
      bit          hold_used;
      bit          stalling;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_taken = 0;
         run_left  = 0;
         hold_left = 0;
         hold_used = 1'b0;
         stalling  = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) rsp_taken++;
         if (!hold_used && rsp_taken >= 150) begin
            hold_used = 1'b1;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (run_left == 0) begin
               pick = $urandom_range(0, 99);
               stalling = 1'b1;
               if (pick < 10) begin
                  stalling = 1'b0;
                  run_left = $urandom_range(40, 120);
               end else if (pick < 50) begin
                  stalling = 1'b0;
                  run_left = $urandom_range(1, 20);
               end else if (pick < 85) run_left = $urandom_range(1, 2);
               else if (pick < 97) run_left = $urandom_range(3, 8);
               else run_left = $urandom_range(15, 50);
            end
            run_left--;
            rsp_stall <= stalling;
         end
      end
   end

   // monitor: predicts on each request beat, checks each response beat
   always @(posedge clock) begin
      queue_op_type     seen;
      queue_result_type want;
      if (reset) begin
         all_done <= 1'b1;
      end else begin
         if (req_valid && !req_stall) begin
            seen.func     = fqkr_pkg::func_type'(req_func);
            seen.value    = req_entry_value;
            seen.position = req_position;
            expected_results.push_back(apply_queue_op(seen));
            requests_seen++;
            if (held_words.size() > peak_fill) peak_fill = held_words.size();
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $display("%0t: response beat with nothing expected, %s %0d, %s 0x%0h, %s %0d",
                        $realtime, "status", rsp_status, "removed", rsp_removed_value,
                        "count", rsp_count);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               report_field("status", 32'(want.status), 32'(rsp_status));
               report_field("removed_value", want.removed, rsp_removed_value);
               report_field("count", 32'(want.count), 32'(rsp_count));
               status_tally[want.status]++;
            end
         end
         all_done <= (expected_results.size() == 0);
      end
   end

   // stimulus plan, reset and end of run
   initial begin
      queue_op_type op;
      foreach (word_pool[i]) word_pool[i] = $urandom();

      // removals on an empty queue
      add_op(fqkr_pkg::FUNC_DEQUEUE,      32'hffff_ffff, 7'd64, 1'b0);
      add_op(fqkr_pkg::FUNC_REMOVE_MATCH, 32'h0000_0000, 7'd0,  1'b0);
      add_op(fqkr_pkg::FUNC_REMOVE_POS,   32'hffff_ffff, 7'd0,  1'b0);
      // extremes and a duplicate word
      add_op(fqkr_pkg::FUNC_ENQUEUE,      32'h0000_0000, 7'd127 & 7'd64, 1'b0);
      add_op(fqkr_pkg::FUNC_ENQUEUE,      32'hffff_ffff, 7'd0,  1'b0);
      add_op(fqkr_pkg::FUNC_ENQUEUE,      32'ha5a5_a5a5, 7'd0,  1'b0);
      add_op(fqkr_pkg::FUNC_ENQUEUE,      32'hffff_ffff, 7'd0,  1'b0);
      add_op(fqkr_pkg::FUNC_ENQUEUE,      32'h5a5a_5a5a, 7'd0,  1'b0);
      // match removes only the first of the duplicates, then a miss
      add_op(fqkr_pkg::FUNC_REMOVE_MATCH, 32'hffff_ffff, 7'd0,  1'b0);
      add_op(fqkr_pkg::FUNC_REMOVE_MATCH, 32'h1234_5678, 7'd0,  1'b0);
      // positions beyond the count, zero as head, the tail, the head, an emptied queue
      add_op(fqkr_pkg::FUNC_REMOVE_POS,   32'h0000_0000, 7'd64, 1'b0);
      add_op(fqkr_pkg::FUNC_REMOVE_POS,   32'h0000_0000, 7'd5,  1'b0);
      add_op(fqkr_pkg::FUNC_REMOVE_POS,   32'h0000_0000, 7'd0,  1'b0);
      add_op(fqkr_pkg::FUNC_REMOVE_POS,   32'h0000_0000, 7'd3,  1'b0);
      add_op(fqkr_pkg::FUNC_REMOVE_POS,   32'h0000_0000, 7'd1,  1'b0);
      add_op(fqkr_pkg::FUNC_DEQUEUE,      32'h0000_0000, 7'd0,  1'b0);
      add_op(fqkr_pkg::FUNC_REMOVE_POS,   32'h0000_0000, 7'd1,  1'b0);
      // positional removal of a duplicated word
      add_op(fqkr_pkg::FUNC_ENQUEUE,      32'h0000_0077, 7'd0,  1'b0);
      add_op(fqkr_pkg::FUNC_ENQUEUE,      32'h0000_0077, 7'd0,  1'b0);
      add_op(fqkr_pkg::FUNC_REMOVE_POS,   32'h0000_0000, 7'd2,  1'b0);
      add_op(fqkr_pkg::FUNC_DEQUEUE,      32'h0000_0000, 7'd0,  1'b0);

      // random phases, alternately filling and draining
      for (int phase = 0; phase < 6; phase++) begin
         burst_phase = (phase == 2);
         if (phase == 1 || phase == 4) add_fill_sequence();
         for (int k = 0; k < 45; k++) begin
            op = random_op((phase % 2 == 0) ? 85 : 20);
            if (k == 0) op.drain_first = 1'b1;
            pending_ops.push_back(op);
         end
      end
      burst_phase = 1'b0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock); while (!(stim_done && all_done));
      repeat (80) @(posedge clock);

      $display("run covered %0d requests, peak fill %0d of %0d entries",
               requests_seen, peak_fill, QUEUE_DEPTH);
      $display("statuses seen: ok %0d, empty %0d, range %0d, no match %0d, full %0d",
               status_tally[fqkr_pkg::STATUS_OK], status_tally[fqkr_pkg::STATUS_EMPTY],
               status_tally[fqkr_pkg::STATUS_RANGE], status_tally[fqkr_pkg::STATUS_NO_MATCH],
               status_tally[fqkr_pkg::STATUS_FULL]);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // watchdog
   initial begin
      #10ms;
      $display("timeout with %0d responses outstanding", expected_results.size());
      $display("FAIL");
      $finish;
   end

endmodule
